// ===== design/mbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbf_pkg: shared types and constants for the message byte fifo
// Op and status codes, controller commands, datapath flags and ring helpers.
// ----------------------------------------------------------------------------
package mbf_pkg;

    // ring geometry
    localparam int CAPACITY     = 1023;
    localparam int SLOTS        = CAPACITY + 1;
    localparam int PTR_W        = $clog2(SLOTS);
    localparam int MAX_BURST    = 64;
    localparam int BURST_W      = $clog2(MAX_BURST + 1);
    localparam int PREFIX_BYTES = 4;
    localparam int PFX_W        = 8 * PREFIX_BYTES;
    localparam int PCNT_W       = $clog2(PREFIX_BYTES + 1);

    // port field widths
    localparam int OP_W    = 3;
    localparam int CNT_W   = 10;
    localparam int DATA_W  = 8;
    localparam int STAT_W  = 3;
    localparam int MSIZE_W = 32;
    localparam int FILL_W  = 10;

    // compare widths
    localparam int SUM_W  = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 2;
    localparam int WIDE_W = (PFX_W > SUM_W) ? PFX_W : SUM_W;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [OP_W-1:0] {
        OP_RAW_PUSH  = 3'd0,
        OP_MSG_PUSH  = 3'd1,
        OP_PUSH_DATA = 3'd2,
        OP_RAW_POP   = 3'd3,
        OP_MSG_POP   = 3'd4,
        OP_DISCARD   = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_NOP       = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_ROOM    = 3'd1,
        ST_SHORT_DATA = 3'd2,
        ST_NO_MSG     = 3'd3,
        ST_BURST      = 3'd4,
        ST_DROPPED    = 3'd5,
        ST_SHORT_MSG  = 3'd6
    } status_t;

    // datapath actions issued by the controller
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PUSH_BEGIN,
        ACT_PFX_WRITE,
        ACT_PUSH_DATA,
        ACT_POP_SETUP,
        ACT_MSG_SETUP,
        ACT_PFX_READ,
        ACT_MSG_CALC,
        ACT_EMIT,
        ACT_DISCARD,
        ACT_CLEAR
    } act_t;

    typedef struct packed {
        logic    capture;
        logic    end_push;
        act_t    act;
        logic    is_msg;
        logic    load;
        status_t res_status;
        logic    res_last;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic room_ok;
        logic store_ok;
        logic burst_big;
        logic short_data;
        logic count_zero;
        logic fill_lt_pfx;
        logic pfx_last;
        logic rem_zero;
        logic rem_one;
        logic short_msg;
    } flags_t;

    // pointer advance with wrap, k below SLOTS
    function automatic ptr_t ptr_add(ptr_t p, ptr_t k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, k};
        if (s >= (PTR_W+1)'(SLOTS))
        begin
            s = s - (PTR_W+1)'(SLOTS);
        end
        return s[PTR_W-1:0];
    endfunction

    // bytes stored between read and write pointers
    function automatic ptr_t ptr_fill(ptr_t w, ptr_t r);
        logic [PTR_W:0] s;
        if (w >= r)
        begin
            s = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            s = {1'b0, w} + (PTR_W+1)'(SLOTS) - {1'b0, r};
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// ===== design/mbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbf_ctrl: message byte fifo controller
// Sequences each transaction and drives datapath actions and result loads.
// ----------------------------------------------------------------------------
module mbf_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mbf_pkg::OP_W-1:0]    op,
    input  mbf_pkg::flags_t             flags,
    output mbf_pkg::cmd_t               cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PFX_WR,
        S_PUSH_DATA,
        S_RAW_CHK,
        S_MSG_CHK,
        S_PFX_RD,
        S_MSG_CALC,
        S_EMIT,
        S_DISCARD,
        S_CLEAR,
        S_NOP
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    mbf_pkg::op_t    op_reg;
    mbf_pkg::op_t    op_next;
    mbf_pkg::op_t    op_in;

    assign op_in    = mbf_pkg::op_t'(op);
    assign in_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd.capture    = 1'b0;
        cmd.end_push   = 1'b0;
        cmd.act        = mbf_pkg::ACT_NONE;
        cmd.is_msg     = (op_reg == mbf_pkg::OP_MSG_PUSH);
        cmd.load       = 1'b0;
        cmd.res_status = mbf_pkg::ST_OK;
        cmd.res_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture  = 1'b1;
                    cmd.end_push = (op_in != mbf_pkg::OP_PUSH_DATA) &&
                                   (op_in != mbf_pkg::OP_NOP);
                    op_next      = op_in;
                    unique case (op_in)
                        mbf_pkg::OP_RAW_PUSH,
                        mbf_pkg::OP_MSG_PUSH:  state_next = S_PUSH_CHK;
                        mbf_pkg::OP_PUSH_DATA: state_next = S_PUSH_DATA;
                        mbf_pkg::OP_RAW_POP:   state_next = S_RAW_CHK;
                        mbf_pkg::OP_MSG_POP:   state_next = S_MSG_CHK;
                        mbf_pkg::OP_DISCARD:   state_next = S_DISCARD;
                        mbf_pkg::OP_CLEAR:     state_next = S_CLEAR;
                        default:               state_next = S_NOP;
                    endcase
                end
            end

            S_PUSH_CHK:
            begin
                if (!flags.room_ok)
                begin
                    if (flags.slot_free)
                    begin
                        cmd.act        = mbf_pkg::ACT_PUSH_BEGIN;
                        cmd.load       = 1'b1;
                        cmd.res_status = mbf_pkg::ST_NO_ROOM;
                        state_next     = S_IDLE;
                    end
                end
                else if (op_reg == mbf_pkg::OP_MSG_PUSH)
                begin
                    cmd.act    = mbf_pkg::ACT_PUSH_BEGIN;
                    state_next = S_PFX_WR;
                end
                else if (flags.slot_free)
                begin
                    cmd.act    = mbf_pkg::ACT_PUSH_BEGIN;
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // length prefix, one byte a cycle, result on the final byte once the slot is free
            S_PFX_WR:
            begin
                if (!flags.pfx_last)
                begin
                    cmd.act = mbf_pkg::ACT_PFX_WRITE;
                end
                else if (flags.slot_free)
                begin
                    cmd.act    = mbf_pkg::ACT_PFX_WRITE;
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_PUSH_DATA:
            begin
                if (flags.slot_free)
                begin
                    cmd.act        = mbf_pkg::ACT_PUSH_DATA;
                    cmd.load       = 1'b1;
                    cmd.res_status = flags.store_ok ? mbf_pkg::ST_OK : mbf_pkg::ST_DROPPED;
                    state_next     = S_IDLE;
                end
            end

            S_RAW_CHK:
            begin
                if (flags.burst_big || flags.short_data || flags.count_zero)
                begin
                    if (flags.slot_free)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_IDLE;
                        if (flags.burst_big)
                        begin
                            cmd.res_status = mbf_pkg::ST_BURST;
                        end
                        else if (flags.short_data)
                        begin
                            cmd.res_status = mbf_pkg::ST_SHORT_DATA;
                        end
                    end
                end
                else
                begin
                    cmd.act    = mbf_pkg::ACT_POP_SETUP;
                    state_next = S_EMIT;
                end
            end

            S_MSG_CHK:
            begin
                if (flags.fill_lt_pfx)
                begin
                    if (flags.slot_free)
                    begin
                        cmd.load       = 1'b1;
                        cmd.res_status = mbf_pkg::ST_NO_MSG;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.act    = mbf_pkg::ACT_MSG_SETUP;
                    state_next = S_PFX_RD;
                end
            end

            S_PFX_RD:
            begin
                cmd.act = mbf_pkg::ACT_PFX_READ;
                if (flags.pfx_last)
                begin
                    state_next = S_MSG_CALC;
                end
            end

            S_MSG_CALC:
            begin
                cmd.act    = mbf_pkg::ACT_MSG_CALC;
                state_next = S_EMIT;
            end

            // one byte per cycle while the output slot frees up
            S_EMIT:
            begin
                if (flags.slot_free)
                begin
                    cmd.act        = mbf_pkg::ACT_EMIT;
                    cmd.load       = 1'b1;
                    cmd.res_status = flags.short_msg ? mbf_pkg::ST_SHORT_MSG : mbf_pkg::ST_OK;
                    cmd.res_last   = flags.rem_zero || flags.rem_one;
                    if (flags.rem_zero || flags.rem_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DISCARD:
            begin
                if (flags.slot_free)
                begin
                    cmd.act        = mbf_pkg::ACT_DISCARD;
                    cmd.load       = 1'b1;
                    cmd.res_status = flags.short_data ? mbf_pkg::ST_SHORT_DATA
                                                      : mbf_pkg::ST_OK;
                    state_next     = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                if (flags.slot_free)
                begin
                    cmd.act    = mbf_pkg::ACT_CLEAR;
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_NOP:
            begin
                if (flags.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= mbf_pkg::OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

// ===== design/mbf_dpath.sv =====
// ----------------------------------------------------------------------------
// mbf_dpath: message byte fifo datapath
// Byte ring memory, pointers, push and pop counters and the result register.
// ----------------------------------------------------------------------------
module mbf_dpath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  mbf_pkg::cmd_t                   cmd,
    output mbf_pkg::flags_t                 flags,
    input  logic [mbf_pkg::CNT_W-1:0]       count,
    input  logic [mbf_pkg::DATA_W-1:0]      data_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mbf_pkg::DATA_W-1:0]      data_out,
    output logic                            data_valid,
    output logic                            last,
    output logic [mbf_pkg::STAT_W-1:0]      status,
    output logic [mbf_pkg::MSIZE_W-1:0]     message_size,
    output logic [mbf_pkg::FILL_W-1:0]      fill_level
);

    // ring storage, no reset
    logic [mbf_pkg::DATA_W-1:0]     mem [mbf_pkg::SLOTS];
    logic                           mem_we;
    logic [mbf_pkg::DATA_W-1:0]     mem_wdata;
    logic [mbf_pkg::DATA_W-1:0]     rd_data_reg;

    // control state
    mbf_pkg::ptr_t                  rp_reg, rp_next;
    mbf_pkg::ptr_t                  wp_reg, wp_next;
    logic [mbf_pkg::CNT_W-1:0]      prem_reg, prem_next;
    logic                           pacc_reg, pacc_next;
    logic [mbf_pkg::PCNT_W-1:0]     pcnt_reg, pcnt_next;
    logic [mbf_pkg::BURST_W-1:0]    rem_reg, rem_next;
    logic                           out_valid_reg, out_valid_next;

    // payload state
    logic [mbf_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [mbf_pkg::DATA_W-1:0]     din_reg, din_next;
    logic [mbf_pkg::PFX_W-1:0]      sr_reg, sr_next;
    logic [mbf_pkg::PFX_W-1:0]      msize_reg, msize_next;
    mbf_pkg::ptr_t                  rest_reg, rest_next;
    logic                           short_reg, short_next;
    logic [mbf_pkg::DATA_W-1:0]     dout_reg, dout_next;
    logic                           dval_reg, dval_next;
    logic                           last_reg, last_next;
    mbf_pkg::status_t               stat_reg, stat_next;
    logic [mbf_pkg::MSIZE_W-1:0]    osize_reg, osize_next;
    logic [mbf_pkg::FILL_W-1:0]     ofill_reg, ofill_next;

    mbf_pkg::ptr_t                  fill;
    logic [mbf_pkg::BURST_W-1:0]    cap;
    logic [mbf_pkg::BURST_W-1:0]    deliver;
    mbf_pkg::ptr_t                  fill_left;
    logic [mbf_pkg::PFX_W-1:0]      msg_left;
    mbf_pkg::ptr_t                  rest;
    logic                           msg_short;
    mbf_pkg::ptr_t                  disc_len;

    assign fill = mbf_pkg::ptr_fill(wp_reg, rp_reg);

    // status flags for the controller
    always_comb
    begin
        flags.slot_free   = !out_valid_reg || out_ready;
        flags.room_ok     = (mbf_pkg::SUM_W'(fill) + mbf_pkg::SUM_W'(count_reg) +
                             (cmd.is_msg ? mbf_pkg::SUM_W'(mbf_pkg::PREFIX_BYTES)
                                         : mbf_pkg::SUM_W'(0)))
                            <= mbf_pkg::SUM_W'(mbf_pkg::CAPACITY);
        flags.store_ok    = (prem_reg != '0) && pacc_reg &&
                            (fill < mbf_pkg::PTR_W'(mbf_pkg::CAPACITY));
        flags.burst_big   = mbf_pkg::SUM_W'(count_reg) > mbf_pkg::SUM_W'(mbf_pkg::MAX_BURST);
        flags.short_data  = mbf_pkg::SUM_W'(count_reg) > mbf_pkg::SUM_W'(fill);
        flags.count_zero  = (count_reg == '0);
        flags.fill_lt_pfx = mbf_pkg::SUM_W'(fill) < mbf_pkg::SUM_W'(mbf_pkg::PREFIX_BYTES);
        flags.pfx_last    = (pcnt_reg == mbf_pkg::PCNT_W'(1));
        flags.rem_zero    = (rem_reg == '0);
        flags.rem_one     = (rem_reg == mbf_pkg::BURST_W'(1));
        flags.short_msg   = short_reg;
    end

    // message pop: bytes delivered and tail skipped
    always_comb
    begin
        if (flags.burst_big)
        begin
            cap = mbf_pkg::BURST_W'(mbf_pkg::MAX_BURST);
        end
        else
        begin
            cap = mbf_pkg::BURST_W'(count_reg);
        end
        deliver = cap;
        if (mbf_pkg::WIDE_W'(deliver) > mbf_pkg::WIDE_W'(msize_reg))
        begin
            deliver = mbf_pkg::BURST_W'(msize_reg);
        end
        if (mbf_pkg::WIDE_W'(deliver) > mbf_pkg::WIDE_W'(fill))
        begin
            deliver = mbf_pkg::BURST_W'(fill);
        end
        fill_left = fill - mbf_pkg::PTR_W'(deliver);
        msg_left  = msize_reg - mbf_pkg::PFX_W'(deliver);
        if (mbf_pkg::WIDE_W'(msg_left) > mbf_pkg::WIDE_W'(fill_left))
        begin
            rest = fill_left;
        end
        else
        begin
            rest = mbf_pkg::PTR_W'(msg_left);
        end
        msg_short = mbf_pkg::WIDE_W'(msize_reg) > mbf_pkg::WIDE_W'(fill);
    end

    // discard length saturates at the fill level
    assign disc_len = flags.short_data ? fill : mbf_pkg::PTR_W'(count_reg);

    // register updates per action
    always_comb
    begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        prem_next      = prem_reg;
        pacc_next      = pacc_reg;
        pcnt_next      = pcnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        din_next       = din_reg;
        sr_next        = sr_reg;
        msize_next     = msize_reg;
        rest_next      = rest_reg;
        short_next     = short_reg;
        dout_next      = dout_reg;
        dval_next      = dval_reg;
        last_next      = last_reg;
        stat_next      = stat_reg;
        osize_next     = osize_reg;
        ofill_next     = ofill_reg;
        mem_we         = 1'b0;
        mem_wdata      = din_reg;

        if (cmd.capture)
        begin
            count_next = count;
            din_next   = data_in;
        end
        if (cmd.end_push)
        begin
            prem_next = '0;
            pacc_next = 1'b0;
        end

        unique case (cmd.act)
            mbf_pkg::ACT_PUSH_BEGIN:
            begin
                prem_next = count_reg;
                pacc_next = flags.room_ok;
                sr_next   = mbf_pkg::PFX_W'(count_reg);
                pcnt_next = mbf_pkg::PCNT_W'(mbf_pkg::PREFIX_BYTES);
            end
            mbf_pkg::ACT_PFX_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = sr_reg[mbf_pkg::DATA_W-1:0];
                wp_next   = mbf_pkg::ptr_add(wp_reg, mbf_pkg::ptr_t'(1));
                sr_next   = sr_reg >> 8;
                pcnt_next = pcnt_reg - mbf_pkg::PCNT_W'(1);
            end
            mbf_pkg::ACT_PUSH_DATA:
            begin
                if (prem_reg != '0)
                begin
                    prem_next = prem_reg - mbf_pkg::CNT_W'(1);
                end
                if (flags.store_ok)
                begin
                    mem_we  = 1'b1;
                    wp_next = mbf_pkg::ptr_add(wp_reg, mbf_pkg::ptr_t'(1));
                end
                if ((prem_reg == '0) || (prem_reg == mbf_pkg::CNT_W'(1)))
                begin
                    pacc_next = 1'b0;
                end
            end
            mbf_pkg::ACT_POP_SETUP:
            begin
                rem_next   = mbf_pkg::BURST_W'(count_reg);
                rest_next  = '0;
                short_next = 1'b0;
                msize_next = '0;
            end
            mbf_pkg::ACT_MSG_SETUP:
            begin
                pcnt_next  = mbf_pkg::PCNT_W'(mbf_pkg::PREFIX_BYTES);
                msize_next = '0;
            end
            mbf_pkg::ACT_PFX_READ:
            begin
                // little-endian prefix shifts in from the top
                msize_next = (msize_reg >> 8) |
                             (mbf_pkg::PFX_W'(rd_data_reg) << (mbf_pkg::PFX_W - 8));
                rp_next    = mbf_pkg::ptr_add(rp_reg, mbf_pkg::ptr_t'(1));
                pcnt_next  = pcnt_reg - mbf_pkg::PCNT_W'(1);
            end
            mbf_pkg::ACT_MSG_CALC:
            begin
                rem_next   = deliver;
                rest_next  = rest;
                short_next = msg_short;
            end
            mbf_pkg::ACT_EMIT:
            begin
                if (flags.rem_zero)
                begin
                    rp_next = mbf_pkg::ptr_add(rp_reg, rest_reg);
                end
                else if (flags.rem_one)
                begin
                    rp_next = mbf_pkg::ptr_add(mbf_pkg::ptr_add(rp_reg, mbf_pkg::ptr_t'(1)),
                                               rest_reg);
                end
                else
                begin
                    rp_next = mbf_pkg::ptr_add(rp_reg, mbf_pkg::ptr_t'(1));
                end
                if (!flags.rem_zero)
                begin
                    rem_next = rem_reg - mbf_pkg::BURST_W'(1);
                end
            end
            mbf_pkg::ACT_DISCARD:
            begin
                rp_next = mbf_pkg::ptr_add(rp_reg, disc_len);
            end
            mbf_pkg::ACT_CLEAR:
            begin
                rp_next = '0;
                wp_next = '0;
            end
            default:
            begin
            end
        endcase

        // result register
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            dval_next      = (cmd.act == mbf_pkg::ACT_EMIT) && !flags.rem_zero;
            dout_next      = dval_next ? rd_data_reg : '0;
            last_next      = cmd.res_last;
            stat_next      = cmd.res_status;
            osize_next     = (cmd.act == mbf_pkg::ACT_EMIT) ?
                             mbf_pkg::MSIZE_W'(msize_reg) : '0;
            ofill_next     = mbf_pkg::FILL_W'(mbf_pkg::ptr_fill(wp_next, rp_next));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ring write and registered read at the next read pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[rp_next];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            prem_reg      <= '0;
            pacc_reg      <= 1'b0;
            pcnt_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            prem_reg      <= prem_next;
            pacc_reg      <= pacc_next;
            pcnt_reg      <= pcnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        din_reg   <= din_next;
        sr_reg    <= sr_next;
        msize_reg <= msize_next;
        rest_reg  <= rest_next;
        short_reg <= short_next;
        dout_reg  <= dout_next;
        dval_reg  <= dval_next;
        last_reg  <= last_next;
        stat_reg  <= stat_next;
        osize_reg <= osize_next;
        ofill_reg <= ofill_next;
    end

    assign out_valid    = out_valid_reg;
    assign data_out     = dout_reg;
    assign data_valid   = dval_reg;
    assign last         = last_reg;
    assign status       = stat_reg;
    assign message_size = osize_reg;
    assign fill_level   = ofill_reg;

endmodule

// ===== design/message_byte_fifo_top.sv =====
// ----------------------------------------------------------------------------
// message_byte_fifo_top: length-prefixed message byte fifo
// A single-result transaction passes its check state, then the result register;
// a message push adds the prefix writes of S_PFX_WR.
// Pops: raw pop starts after its check state, message pop after the check,
// prefix reads and length calc; then one byte per cycle while the slot is free.
// A new transaction is accepted only once the controller is back in idle.
// Reset: asynchronous, clears pointers and push state; ring contents untouched.
// ----------------------------------------------------------------------------
module message_byte_fifo_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mbf_pkg::OP_W-1:0]        op,
    input  logic [mbf_pkg::CNT_W-1:0]       count,
    input  logic [mbf_pkg::DATA_W-1:0]      data_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mbf_pkg::DATA_W-1:0]      data_out,
    output logic                            data_valid,
    output logic                            last,
    output logic [mbf_pkg::STAT_W-1:0]      status,
    output logic [mbf_pkg::MSIZE_W-1:0]     message_size,
    output logic [mbf_pkg::FILL_W-1:0]      fill_level
);

    mbf_pkg::cmd_t      cmd;
    mbf_pkg::flags_t    flags;

    // controller
    mbf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .flags    (flags),
        .cmd      (cmd)
    );

    // datapath
    mbf_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .flags        (flags),
        .count        (count),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_out     (data_out),
        .data_valid   (data_valid),
        .last         (last),
        .status       (status),
        .message_size (message_size),
        .fill_level   (fill_level)
    );

    // a result load never overwrites one still waiting
    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> flags.slot_free)
        else $error("result loaded over a pending result");

    // no result is produced in the cycle a transaction is accepted
    a_accept_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !cmd.load)
        else $error("result load during accept");

    // popped bytes only carry ok or short message status
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_valid) |->
            (status == mbf_pkg::ST_OK || status == mbf_pkg::ST_SHORT_MSG))
        else $error("popped byte with error status");

    // results without data are always the final one of a transaction
    a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !data_valid) |-> (last && data_out == '0))
        else $error("data-less result not final");

endmodule

// ===== verif/message_byte_fifo_top_test.sv =====
// ----------------------------------------------------------------------------
// message_byte_fifo_top_test: self-checking bench for the message byte fifo
// Drives push, pop, message, discard and clear transactions with random idle
// gaps and output stalls, predicts every result from a local copy of the
// ring and pointers, and compares results field by field in arrival order.
// ----------------------------------------------------------------------------
module message_byte_fifo_top_test;

    import mbf_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [DATA_W-1:0]  data;
        logic               dv;
        logic               last;
        status_t            st;
        logic [MSIZE_W-1:0] msize;
        logic [FILL_W-1:0]  fill;
    } fifo_reply_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [OP_W-1:0]    op;
    logic [CNT_W-1:0]   count;
    logic [DATA_W-1:0]  data_in;
    logic               out_valid;
    logic               out_ready;
    logic [DATA_W-1:0]  data_out;
    logic               data_valid;
    logic               last;
    logic [STAT_W-1:0]  status;
    logic [MSIZE_W-1:0] message_size;
    logic [FILL_W-1:0]  fill_level;

    // local copy of the fifo state
    logic [DATA_W-1:0] ring_copy [SLOTS];
    int unsigned       rd_ptr = 0;
    int unsigned       wr_ptr = 0;
    int unsigned       push_left = 0;
    bit                push_ok = 1'b0;

    fifo_reply_t predicted_replies[$];
    int          error_count = 0;
    int unsigned items_sent = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;

    message_byte_fifo_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .count        (count),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_out     (data_out),
        .data_valid   (data_valid),
        .last         (last),
        .status       (status),
        .message_size (message_size),
        .fill_level   (fill_level)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ring helpers for the prediction
    function automatic int unsigned ring_fill();
        return (wr_ptr + SLOTS - rd_ptr) % SLOTS;
    endfunction

    function automatic void store_byte(logic [DATA_W-1:0] b);
        ring_copy[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % SLOTS;
    endfunction

    function automatic logic [DATA_W-1:0] take_byte();
        logic [DATA_W-1:0] b;
        b = ring_copy[rd_ptr];
        rd_ptr = (rd_ptr + 1) % SLOTS;
        return b;
    endfunction

    function automatic void queue_reply(logic [DATA_W-1:0] b, logic dv, logic lst,
                                        status_t st, logic [MSIZE_W-1:0] msize);
        fifo_reply_t r;
        r.data  = b;
        r.dv    = dv;
        r.last  = lst;
        r.st    = st;
        r.msize = msize;
        r.fill  = ring_fill();
        predicted_replies.push_back(r);
    endfunction

    // work out the results of one accepted transaction and update the copy
    function automatic void apply_fifo_op(op_t o, int unsigned cnt, logic [DATA_W-1:0] din);
        int unsigned       need;
        int unsigned       i;
        status_t           st;
        logic [DATA_W-1:0] b;
        longint unsigned   msize;
        longint unsigned   f;
        longint unsigned   d;
        longint unsigned   tail;
        if (o != OP_PUSH_DATA && o != OP_NOP)
        begin
            push_left = 0;
            push_ok = 1'b0;
        end
        case (o)
            OP_RAW_PUSH, OP_MSG_PUSH:
            begin
                need = cnt + ((o == OP_MSG_PUSH) ? PREFIX_BYTES : 0);
                push_left = cnt;
                if (ring_fill() + need > CAPACITY)
                begin
                    push_ok = 1'b0;
                    queue_reply(0, 1'b0, 1'b1, ST_NO_ROOM, 0);
                end
                else
                begin
                    push_ok = 1'b1;
                    if (o == OP_MSG_PUSH)
                    begin
                        for (i = 0; i < PREFIX_BYTES; i++)
                        begin
                            store_byte(DATA_W'(cnt >> (8 * i)));
                        end
                    end
                    queue_reply(0, 1'b0, 1'b1, ST_OK, 0);
                end
            end
            OP_PUSH_DATA:
            begin
                st = ST_DROPPED;
                if (push_left > 0)
                begin
                    push_left--;
                    if (push_ok && ring_fill() < CAPACITY)
                    begin
                        store_byte(din);
                        st = ST_OK;
                    end
                end
                if (push_left == 0)
                begin
                    push_ok = 1'b0;
                end
                queue_reply(0, 1'b0, 1'b1, st, 0);
            end
            OP_RAW_POP:
            begin
                if (cnt > MAX_BURST)
                begin
                    queue_reply(0, 1'b0, 1'b1, ST_BURST, 0);
                end
                else if (ring_fill() < cnt)
                begin
                    queue_reply(0, 1'b0, 1'b1, ST_SHORT_DATA, 0);
                end
                else if (cnt == 0)
                begin
                    queue_reply(0, 1'b0, 1'b1, ST_OK, 0);
                end
                else
                begin
                    for (i = 0; i < cnt; i++)
                    begin
                        b = take_byte();
                        queue_reply(b, 1'b1, i + 1 == cnt, ST_OK, 0);
                    end
                end
            end
            OP_MSG_POP:
            begin
                if (ring_fill() < PREFIX_BYTES)
                begin
                    queue_reply(0, 1'b0, 1'b1, ST_NO_MSG, 0);
                end
                else
                begin
                    // little-endian length prefix, then capped delivery and tail drop
                    msize = 0;
                    for (i = 0; i < PREFIX_BYTES; i++)
                    begin
                        msize |= longint'(take_byte()) << (8 * i);
                    end
                    f = ring_fill();
                    st = (msize > f) ? ST_SHORT_MSG : ST_OK;
                    d = (cnt < MAX_BURST) ? cnt : MAX_BURST;
                    if (d > msize)
                    begin
                        d = msize;
                    end
                    if (d > f)
                    begin
                        d = f;
                    end
                    tail = msize - d;
                    if (tail > f - d)
                    begin
                        tail = f - d;
                    end
                    if (d == 0)
                    begin
                        rd_ptr = (rd_ptr + tail) % SLOTS;
                        queue_reply(0, 1'b0, 1'b1, st, msize);
                    end
                    else
                    begin
                        for (i = 0; i < d; i++)
                        begin
                            b = take_byte();
                            if (i + 1 == d)
                            begin
                                rd_ptr = (rd_ptr + tail) % SLOTS;
                            end
                            queue_reply(b, 1'b1, i + 1 == d, st, msize);
                        end
                    end
                end
            end
            OP_DISCARD:
            begin
                f = ring_fill();
                d = (cnt < f) ? cnt : f;
                rd_ptr = (rd_ptr + d) % SLOTS;
                queue_reply(0, 1'b0, 1'b1, (cnt > f) ? ST_SHORT_DATA : ST_OK, 0);
            end
            OP_CLEAR:
            begin
                rd_ptr = 0;
                wr_ptr = 0;
                queue_reply(0, 1'b0, 1'b1, ST_OK, 0);
            end
            default:
            begin
                queue_reply(0, 1'b0, 1'b1, ST_OK, 0);
            end
        endcase
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // compare one result with the oldest prediction
    task automatic check_reply();
        fifo_reply_t e;
        if (predicted_replies.size() == 0)
        begin
            note_error($sformatf("unexpected result: data %02h dv %0b status %0d fill %0d",
                                 data_out, data_valid, status, fill_level));
            return;
        end
        e = predicted_replies.pop_front();
        if (data_out !== e.data || data_valid !== e.dv || last !== e.last
            || status !== e.st || message_size !== e.msize || fill_level !== e.fill)
        begin
            note_error($sformatf({"expected data %02h dv %0b last %0b status %0d size %0d ",
                                  "fill %0d, got data %02h dv %0b last %0b status %0d ",
                                  "size %0d fill %0d"},
                                 e.data, e.dv, e.last, e.st, e.msize, e.fill,
                                 data_out, data_valid, last, status, message_size,
                                 fill_level));
        end
    endtask

    // result side: check each result, drive ready with stalls and hold-off
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                check_reply();
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // offer one transaction, optionally after an idle burst, and predict it
    task automatic send_item(op_t o, logic [CNT_W-1:0] c, logic [DATA_W-1:0] d);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        op       <= o;
        count    <= c;
        data_in  <= d;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        apply_fifo_op(o, c, d);
    endtask

    function automatic logic [DATA_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    // push command followed by its data bytes, cut short when broken
    task automatic send_burst(op_t begin_op, int unsigned len, bit broken);
        int unsigned n;
        int unsigned i;
        n = broken ? $urandom_range(0, len) : len;
        send_item(begin_op, CNT_W'(len), 8'h00);
        for (i = 0; i < n; i++)
        begin
            send_item(OP_PUSH_DATA, 0, pick_byte());
        end
    endtask

    // raw push and pop, empty pop, clear with data stored
    task automatic test_raw_basics();
        send_item(OP_RAW_POP, 0, 8'h00);
        send_item(OP_RAW_PUSH, 3, 8'h00);
        send_item(OP_PUSH_DATA, 0, 8'h00);
        send_item(OP_PUSH_DATA, 0, 8'hFF);
        send_item(OP_PUSH_DATA, 0, 8'h5A);
        send_item(OP_RAW_POP, 2, 8'h00);
        send_item(OP_CLEAR, 0, 8'h00);
    endtask

    // oversized and short pops, no message, over-discard, unused op
    task automatic test_error_paths();
        send_item(OP_RAW_POP, MAX_BURST + 1, 8'h00);
        send_item(OP_RAW_POP, 1023, 8'h00);
        send_item(OP_RAW_POP, 1, 8'h00);
        send_item(OP_MSG_POP, 0, 8'h00);
        send_item(OP_DISCARD, 5, 8'h00);
        send_item(OP_NOP, 1023, 8'hFF);
    endtask

    // truncated message read and empty message delivery
    task automatic test_message_paths();
        send_burst(OP_MSG_PUSH, 2, 1'b0);
        send_item(OP_MSG_POP, 1, 8'h00);
        send_burst(OP_MSG_PUSH, 0, 1'b0);
        send_item(OP_MSG_POP, 1023, 8'h00);
    endtask

    // refused, stray and interrupted pushes, then a message popped in part
    task automatic test_push_faults();
        send_burst(OP_RAW_PUSH, 1, 1'b0);
        send_item(OP_RAW_PUSH, 1023, 8'h00);
        send_item(OP_PUSH_DATA, 0, 8'h11);
        send_item(OP_DISCARD, 1023, 8'h00);
        send_item(OP_PUSH_DATA, 0, 8'h22);
        send_item(OP_RAW_PUSH, 4, 8'h00);
        send_item(OP_PUSH_DATA, 0, 8'h33);
        send_item(OP_NOP, 0, 8'h00);
        send_item(OP_PUSH_DATA, 0, 8'h44);
        send_item(OP_DISCARD, 2, 8'h00);
        send_item(OP_PUSH_DATA, 0, 8'h55);
        send_burst(OP_MSG_PUSH, 10, 1'b0);
        send_item(OP_MSG_POP, 8, 8'h00);
    endtask

    // fill the ring to capacity, refuse more, then drain with an over-discard
    task automatic test_full_ring();
        int unsigned i;
        send_item(OP_DISCARD, 1023, 8'h00);
        send_item(OP_RAW_PUSH, CAPACITY, 8'h00);
        for (i = 0; i < CAPACITY; i++)
        begin
            send_item(OP_PUSH_DATA, 0, pick_byte());
        end
        send_item(OP_RAW_PUSH, 0, 8'h00);
        send_item(OP_RAW_PUSH, 1, 8'h00);
        send_item(OP_MSG_PUSH, 0, 8'h00);
        send_item(OP_RAW_POP, MAX_BURST, 8'h00);
        send_item(OP_DISCARD, 1023, 8'h00);
    endtask

    // receiver holds off while the sender keeps offering transactions
    task automatic test_backpressure();
        idle_en = 1'b0;
        hold_req = 1'b1;
        send_burst(OP_MSG_PUSH, 20, 1'b0);
        send_item(OP_MSG_POP, MAX_BURST, 8'h00);
        send_burst(OP_RAW_PUSH, 12, 1'b0);
        send_item(OP_RAW_POP, 12, 8'h00);
        send_item(OP_DISCARD, 3, 8'h00);
        send_item(OP_CLEAR, 0, 8'h00);
        idle_en = 1'b1;
    endtask

    // mostly well-formed message and raw traffic with some noise
    task automatic test_random_traffic(int unsigned n_items, bit allow_idle);
        int unsigned start;
        int unsigned pick;
        int unsigned room;
        int unsigned len;
        int unsigned f;
        int unsigned c;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if (allow_idle && $urandom_range(0, 15) == 0)
            begin
                idle_en = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            f = ring_fill();
            room = CAPACITY - f;
            if (pick < 45)
            begin
                // message or raw push sequence
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 200)
                                                  : $urandom_range(0, 24);
                if (len + PREFIX_BYTES > room && $urandom_range(0, 3) != 0)
                begin
                    len = (room > PREFIX_BYTES + 24) ? $urandom_range(0, 24) : 0;
                end
                send_burst((pick < 30) ? OP_MSG_PUSH : OP_RAW_PUSH, len,
                           $urandom_range(0, 7) == 0);
            end
            else if (pick < 62)
            begin
                c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 70);
                send_item(OP_MSG_POP, CNT_W'(c), pick_byte());
            end
            else if (pick < 74)
            begin
                c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                    : $urandom_range(0, (f < MAX_BURST) ? f : MAX_BURST);
                send_item(OP_RAW_POP, CNT_W'(c), pick_byte());
            end
            else if (pick < 82)
            begin
                c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 20);
                send_item(OP_DISCARD, CNT_W'(c), pick_byte());
            end
            else if (pick < 85)
            begin
                send_item(OP_CLEAR, CNT_W'($urandom_range(0, 1023)), pick_byte());
            end
            else
            begin
                send_item(op_t'($urandom_range(0, 7)), CNT_W'($urandom_range(0, 1023)),
                          pick_byte());
            end
        end
    endtask

    // stimulus sequence
    initial
    begin : main
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        op       <= OP_NOP;
        count    <= '0;
        data_in  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_raw_basics();
        test_error_paths();
        test_message_paths();
        test_push_faults();
        test_full_ring();
        test_backpressure();
        test_random_traffic(210, 1'b1);
        idle_en = 1'b0;
        test_random_traffic(40, 1'b0);
        in_valid <= 1'b0;
        while (predicted_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && predicted_replies.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mbf_pkg.sv
design/mbf_ctrl.sv
design/mbf_dpath.sv
design/message_byte_fifo_top.sv
verif/message_byte_fifo_top_test.sv
